FILE: rtl/dssp_pkg.sv
// dssp_pkg: shared types and constants of the decimal size string parser
// used by dssp_front, dssp_queue, dssp_back and the top level
// no dependencies
package dssp_pkg;

    // ascii codes the parser looks at
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_G     = 8'h47;

    // unit codes
    localparam logic [1:0] UNITS_B  = 2'd0;
    localparam logic [1:0] UNITS_KB = 2'd1;
    localparam logic [1:0] UNITS_MB = 2'd2;
    localparam logic [1:0] UNITS_GB = 2'd3;

    // number limits
    localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // parse phases
    typedef enum logic [2:0] {
        PH_LEAD,
        PH_NUM,
        PH_GAP,
        PH_UNIT,
        PH_UTRAIL
    } phase_t;

    // one classified character word
    typedef struct packed {
        logic       is_ws;
        logic       is_digit;
        logic       is_sign;
        logic       is_minus;
        logic [3:0] digit;
        logic [7:0] up_ch;
        logic       last;
    } word_t;

    // handshake between two stages
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

FILE: rtl/dssp_front.sv
// dssp_front: classifies each incoming character word
// depends on dssp_pkg
module dssp_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] ch
    input  logic                s_tlast,   // last
    output dssp_pkg::hs_t       push,
    input  logic                push_ready,
    output dssp_pkg::word_t     push_word
);

    logic [7:0] ch;
    assign ch = s_tdata;

    // handshake passes straight through to the queue
    assign push.valid = s_tvalid;
    assign push.ready = push_ready;
    assign s_tready   = push_ready;

    // character classes and upper-case folding
    always_comb begin
        push_word.is_ws    = (ch == dssp_pkg::CH_SPACE) ||
                             (ch >= dssp_pkg::CH_TAB && ch <= dssp_pkg::CH_CR);
        push_word.is_digit = (ch >= dssp_pkg::CH_ZERO && ch <= dssp_pkg::CH_NINE);
        push_word.is_sign  = (ch == dssp_pkg::CH_PLUS) || (ch == dssp_pkg::CH_MINUS);
        push_word.is_minus = (ch == dssp_pkg::CH_MINUS);
        push_word.digit    = ch[3:0];
        push_word.up_ch    = (ch >= dssp_pkg::CH_LOW_A && ch <= dssp_pkg::CH_LOW_Z) ?
                             (ch - dssp_pkg::CH_CASE) : ch;
        push_word.last     = s_tlast;
    end

endmodule

FILE: rtl/dssp_queue.sv
// dssp_queue: two-entry queue of classified words between front and back
// depends on dssp_pkg
module dssp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  dssp_pkg::hs_t   push,
    input  dssp_pkg::word_t push_word,
    output logic            push_ready,
    output logic            pop_valid,
    input  logic            pop_ready,
    output dssp_pkg::word_t pop_word
);

    dssp_pkg::word_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_word   = entry_reg[rd_ptr_reg];

    assign do_push = push.valid && push.ready;
    assign do_pop  = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: rtl/dssp_back.sv
// dssp_back: parse state machine, number accumulation and result register
// depends on dssp_pkg
module dssp_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      default_units,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  dssp_pkg::word_t pop_word,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic            res_status,
    output logic [63:0]     res_value,
    output logic [1:0]      res_units,
    output logic            res_saturated
);

    dssp_pkg::phase_t phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic             sign_seen_reg, sign_seen_next;
    logic             digit_seen_reg, digit_seen_next;
    logic [63:0]      mag_reg, mag_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       uc0_reg, uc0_next;
    logic [7:0]       uc1_reg, uc1_next;
    logic [1:0]       ulen_reg, ulen_next;
    logic             err_reg, err_next;

    logic             out_valid_reg, out_valid_next;
    logic             status_reg, status_next;
    logic [63:0]      value_reg, value_next;
    logic [1:0]       units_reg, units_next;
    logic             sat_reg, sat_next;

    logic             pop;
    logic             numeric;
    logic             do_num, do_unit;
    logic             fail;
    logic [67:0]      mag_ext;
    logic [67:0]      sum;

    assign pop_ready     = !out_valid_reg || m_tready;
    assign pop           = pop_valid && pop_ready;
    assign numeric       = pop_word.is_digit || pop_word.is_sign;

    assign m_tvalid      = out_valid_reg;
    assign res_status    = status_reg;
    assign res_value     = value_reg;
    assign res_units     = units_reg;
    assign res_saturated = sat_reg;

    // times ten plus digit, kept wide for the saturation compare
    assign mag_ext = {4'd0, mag_reg};
    assign sum     = (mag_ext << 3) + (mag_ext << 1) + {64'd0, pop_word.digit};

    // next state and result
    always_comb begin
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        sign_seen_next  = sign_seen_reg;
        digit_seen_next = digit_seen_reg;
        mag_next        = mag_reg;
        ovf_next        = ovf_reg;
        uc0_next        = uc0_reg;
        uc1_next        = uc1_reg;
        ulen_next       = ulen_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        status_next     = status_reg;
        value_next      = value_reg;
        units_next      = units_reg;
        sat_next        = sat_reg;
        do_num          = 1'b0;
        do_unit         = 1'b0;
        fail            = 1'b0;

        if (pop) begin
            // phase transitions
            unique case (phase_reg)
                dssp_pkg::PH_LEAD: begin
                    if (!pop_word.is_ws) begin
                        if (numeric) begin
                            phase_next = dssp_pkg::PH_NUM;
                            do_num     = 1'b1;
                        end else begin
                            err_next = 1'b1;
                            do_unit  = 1'b1;
                        end
                    end
                end
                dssp_pkg::PH_NUM: begin
                    if (numeric) begin
                        do_num = 1'b1;
                    end else if (pop_word.is_ws) begin
                        phase_next = dssp_pkg::PH_GAP;
                    end else begin
                        do_unit = 1'b1;
                    end
                end
                dssp_pkg::PH_GAP: begin
                    if (!pop_word.is_ws) begin
                        do_unit = 1'b1;
                    end
                end
                dssp_pkg::PH_UNIT: begin
                    if (pop_word.is_ws) begin
                        phase_next = dssp_pkg::PH_UTRAIL;
                    end else begin
                        do_unit = 1'b1;
                    end
                end
                dssp_pkg::PH_UTRAIL: begin
                    // whitespace inside the suffix
                    if (!pop_word.is_ws) begin
                        err_next = 1'b1;
                    end
                end
                default: begin
                    phase_next = dssp_pkg::PH_LEAD;
                end
            endcase

            // digit or sign of the numeric part
            if (do_num) begin
                if (pop_word.is_digit) begin
                    digit_seen_next = 1'b1;
                    if (ovf_reg || (sum > {4'd0, dssp_pkg::MAG_LIMIT})) begin
                        ovf_next = 1'b1;
                        mag_next = dssp_pkg::MAG_LIMIT;
                    end else begin
                        mag_next = sum[63:0];
                    end
                end else begin
                    if (sign_seen_reg || digit_seen_reg) begin
                        err_next = 1'b1;
                    end
                    sign_seen_next = 1'b1;
                    if (pop_word.is_minus) begin
                        neg_next = 1'b1;
                    end
                end
            end

            // suffix character capture
            if (do_unit) begin
                phase_next = dssp_pkg::PH_UNIT;
                if (ulen_reg == 2'd0) begin
                    uc0_next  = pop_word.up_ch;
                    ulen_next = 2'd1;
                end else if (ulen_reg == 2'd1) begin
                    uc1_next  = pop_word.up_ch;
                    ulen_next = 2'd2;
                end else begin
                    err_next = 1'b1;
                end
            end

            // result on the last character, then back to the start
            if (pop_word.last) begin
                fail       = err_next || !digit_seen_next;
                units_next = default_units;
                if (!fail && ulen_next != 2'd0) begin
                    if (ulen_next == 2'd1 && uc0_next == dssp_pkg::CH_B) begin
                        units_next = dssp_pkg::UNITS_B;
                    end else if (ulen_next == 2'd2 && uc1_next == dssp_pkg::CH_B &&
                                 uc0_next == dssp_pkg::CH_K) begin
                        units_next = dssp_pkg::UNITS_KB;
                    end else if (ulen_next == 2'd2 && uc1_next == dssp_pkg::CH_B &&
                                 uc0_next == dssp_pkg::CH_M) begin
                        units_next = dssp_pkg::UNITS_MB;
                    end else if (ulen_next == 2'd2 && uc1_next == dssp_pkg::CH_B &&
                                 uc0_next == dssp_pkg::CH_G) begin
                        units_next = dssp_pkg::UNITS_GB;
                    end else begin
                        fail = 1'b1;
                    end
                end

                value_next = 64'd0;
                sat_next   = 1'b0;
                if (fail) begin
                    units_next = dssp_pkg::UNITS_B;
                end else if (neg_next) begin
                    value_next = 64'd0 - mag_next;
                    sat_next   = ovf_next;
                end else if (ovf_next || mag_next[63]) begin
                    value_next = dssp_pkg::POS_MAX;
                    sat_next   = 1'b1;
                end else begin
                    value_next = mag_next;
                end
                status_next    = fail ? dssp_pkg::STATUS_FAIL : dssp_pkg::STATUS_OK;
                out_valid_next = 1'b1;

                phase_next      = dssp_pkg::PH_LEAD;
                neg_next        = 1'b0;
                sign_seen_next  = 1'b0;
                digit_seen_next = 1'b0;
                mag_next        = 64'd0;
                ovf_next        = 1'b0;
                uc0_next        = 8'd0;
                uc1_next        = 8'd0;
                ulen_next       = 2'd0;
                err_next        = 1'b0;
            end
        end
    end

    // parse state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= dssp_pkg::PH_LEAD;
            neg_reg        <= 1'b0;
            sign_seen_reg  <= 1'b0;
            digit_seen_reg <= 1'b0;
            mag_reg        <= 64'd0;
            ovf_reg        <= 1'b0;
            uc0_reg        <= 8'd0;
            uc1_reg        <= 8'd0;
            ulen_reg       <= 2'd0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            sign_seen_reg  <= sign_seen_next;
            digit_seen_reg <= digit_seen_next;
            mag_reg        <= mag_next;
            ovf_reg        <= ovf_next;
            uc0_reg        <= uc0_next;
            uc1_reg        <= uc1_next;
            ulen_reg       <= ulen_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        value_reg  <= value_next;
        units_reg  <= units_next;
        sat_reg    <= sat_next;
    end

endmodule

FILE: rtl/decimal_size_string_parser.sv
// decimal_size_string_parser: top level of the size string parser
// instantiates dssp_front, dssp_queue and dssp_back; uses dssp_pkg
//
// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    s_tdata[7:0] ch, s_tlast last
// m_        out  m_tvalid / m_tready    m_tuser status, m_tdata value/units/saturated
// cfg_      in   cfg_valid / cfg_ready  cfg_data[1:0] default_units
//
// one character word per cycle while the queue has room; the back end updates its
// parse state once per word (one times-ten add and saturation compare per digit)
// the result is registered in the cycle after the last word leaves the two-entry queue
// reset is synchronous, active low, and takes effect at the next edge
// a stalled m_ side holds the result; the queue keeps taking words until full

module decimal_size_string_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] ch
    input  logic        s_tlast,    // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [63:0] value_in_units, [65:64] units,
                                    // [66] saturated, [71:67] zero
    output logic        m_tuser,    // [0] status
    output logic        m_tlast_unused_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data    // [1:0] default_units
);

    dssp_pkg::hs_t   push;
    dssp_pkg::word_t push_word;
    dssp_pkg::word_t pop_word;
    logic            push_ready;
    logic            pop_valid;
    logic            pop_ready;
    logic [1:0]      default_units_reg;
    logic            res_status;
    logic [63:0]     res_value;
    logic [1:0]      res_units;
    logic            res_saturated;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_units_reg <= dssp_pkg::UNITS_B;
        end else if (cfg_valid && cfg_ready) begin
            default_units_reg <= cfg_data;
        end
    end

    dssp_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    dssp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_word  (push_word),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    dssp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .default_units (default_units_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_word      (pop_word),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .res_status    (res_status),
        .res_value     (res_value),
        .res_units     (res_units),
        .res_saturated (res_saturated)
    );

    // result packing
    assign m_tdata          = {5'd0, res_saturated, res_units, res_value};
    assign m_tuser          = res_status;
    assign m_tlast_unused_n = m_tvalid;

endmodule

FILE: dv/decimal_size_string_parser_tb.sv
// decimal_size_string_parser_tb: self-checking bench for the size string parser
// streams hand-picked and random size strings, mirrors the parse in the bench and
// checks every m_ result word; depends on dssp_pkg and the parser rtl
module decimal_size_string_parser_tb;
    import dssp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_IDLE       = 10;
    localparam int REPORT_LIMIT   = 10;
    localparam int HOLD_CYCLES    = 150;

    typedef logic [7:0] text_t [$];

    typedef struct packed {
        logic        status;
        logic [63:0] value;
        logic [1:0]  units;
        logic        saturated;
    } size_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;    // [7:0] ch
    logic        s_tlast   = 1'b0;     // last
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;              // [63:0] value_in_units, [65:64] units, [66] saturated
    logic        m_tuser;              // [0] status
    logic        m_tlast_unused_n;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = 2'd0;     // [1:0] default_units

    decimal_size_string_parser dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast_unused_n (m_tlast_unused_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    always #5 aclk = ~aclk;

    // mirrored parse state and register
    phase_t      scan_phase;
    logic        neg_seen;
    logic        sign_seen;
    logic        digit_seen;
    logic        mag_overflow;
    logic        malformed;
    logic [63:0] magnitude;
    logic [7:0]  suffix_ch [2];
    int          suffix_len;
    logic [1:0]  default_units;

    size_result_t pending_sizes [$];
    int           mismatch_count    = 0;
    int           idle_cycles       = 0;
    bit           steady_flow       = 1'b0;
    int           sink_hold_cycles  = 0;

    string      limit_numbers [5] = '{"9223372036854775807", "9223372036854775808",
                                      "9223372036854775809", "18446744073709551616",
                                      "0000000000000000000042"};
    logic [7:0] unit_letters [3]  = '{CH_K, CH_M, CH_G};

    task automatic clear_scan();
        scan_phase   = PH_LEAD;
        neg_seen     = 1'b0;
        sign_seen    = 1'b0;
        digit_seen   = 1'b0;
        mag_overflow = 1'b0;
        malformed    = 1'b0;
        magnitude    = 64'd0;
        suffix_ch[0] = 8'h00;
        suffix_ch[1] = 8'h00;
        suffix_len   = 0;
    endtask

    // digit or sign of the numeric part
    task automatic take_number_char(input logic [7:0] c);
        logic [63:0] d;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 64'(c - CH_ZERO);
            digit_seen = 1'b1;
            if (mag_overflow || magnitude > (MAG_LIMIT - d) / 64'd10) begin
                mag_overflow = 1'b1;
                magnitude    = MAG_LIMIT;
            end else begin
                magnitude = magnitude * 64'd10 + d;
            end
        end else begin
            if (sign_seen || digit_seen) begin
                malformed = 1'b1;
            end
            sign_seen = 1'b1;
            if (c == CH_MINUS) begin
                neg_seen = 1'b1;
            end
        end
    endtask

    // suffix character, kept upper case, at most two
    task automatic take_suffix_char(input logic [7:0] c);
        if (suffix_len < 2) begin
            suffix_ch[suffix_len] = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CH_CASE : c;
            suffix_len++;
        end else begin
            malformed = 1'b1;
        end
        scan_phase = PH_UNIT;
    endtask

    // advance the mirrored parse by one character word, queue a result on last
    task automatic predict_char(input logic [7:0] c, input logic last);
        logic         ws;
        logic         numeric;
        size_result_t r;
        ws      = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        numeric = (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS;
        case (scan_phase)
            PH_LEAD: begin
                if (!ws && numeric) begin
                    scan_phase = PH_NUM;
                    take_number_char(c);
                end else if (!ws) begin
                    // suffix with no number in front
                    malformed = 1'b1;
                    take_suffix_char(c);
                end
            end
            PH_NUM: begin
                if (numeric) begin
                    take_number_char(c);
                end else if (ws) begin
                    scan_phase = PH_GAP;
                end else begin
                    take_suffix_char(c);
                end
            end
            PH_GAP: begin
                if (!ws) begin
                    take_suffix_char(c);
                end
            end
            PH_UNIT: begin
                if (ws) begin
                    scan_phase = PH_UTRAIL;
                end else begin
                    take_suffix_char(c);
                end
            end
            default: begin
                // whitespace inside the suffix
                if (!ws) begin
                    malformed = 1'b1;
                end
            end
        endcase
        if (last) begin
            r.status    = (malformed || !digit_seen) ? STATUS_FAIL : STATUS_OK;
            r.units     = default_units;
            r.value     = 64'd0;
            r.saturated = 1'b0;
            if (r.status == STATUS_OK && suffix_len > 0) begin
                if (suffix_len == 1 && suffix_ch[0] == CH_B) begin
                    r.units = UNITS_B;
                end else if (suffix_len == 2 && suffix_ch[1] == CH_B && suffix_ch[0] == CH_K) begin
                    r.units = UNITS_KB;
                end else if (suffix_len == 2 && suffix_ch[1] == CH_B && suffix_ch[0] == CH_M) begin
                    r.units = UNITS_MB;
                end else if (suffix_len == 2 && suffix_ch[1] == CH_B && suffix_ch[0] == CH_G) begin
                    r.units = UNITS_GB;
                end else begin
                    r.status = STATUS_FAIL;
                end
            end
            if (r.status == STATUS_OK) begin
                if (neg_seen) begin
                    r.value     = 64'd0 - magnitude;
                    r.saturated = mag_overflow;
                end else if (mag_overflow || magnitude >= MAG_LIMIT) begin
                    r.value     = POS_MAX;
                    r.saturated = 1'b1;
                end else begin
                    r.value = magnitude;
                end
            end else begin
                r.units = UNITS_B;
            end
            pending_sizes.push_back(r);
            clear_scan();
        end
    endtask

    // offer one character word after a random gap (no gap in steady flow), predict once accepted
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_char(c, last);
    endtask

    task automatic send_bytes(input text_t t);
        foreach (t[i]) begin
            send_char(t[i], i == t.size() - 1);
        end
    endtask

    task automatic send_text(input string str);
        text_t t;
        t = {};
        foreach (str[i]) begin
            t.push_back(str[i]);
        end
        send_bytes(t);
    endtask

    // wait for every queued result, then let in-flight words settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_sizes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_default_units(input logic [1:0] units);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= units;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        default_units = units;
    endtask

    function automatic logic [7:0] pick_blank();
        return ($urandom_range(0, 2) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    // mostly well-formed size strings with random content, some mutated, some noise
    task automatic make_size_string(output text_t s);
        string      num;
        int         kind;
        int         unit_pick;
        logic [7:0] stray;
        s    = {};
        num  = "";
        kind = $urandom_range(0, 9);
        if (kind >= 8) begin
            repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) s.push_back(pick_blank());
        case ($urandom_range(0, 3))
            0: s.push_back(CH_PLUS);
            1: s.push_back(CH_MINUS);
            default: ;
        endcase
        case ($urandom_range(0, 6))
            0: num = $sformatf("%0d", $urandom_range(0, 9));
            1: num = $sformatf("%0d", $urandom_range(0, 99999));
            2: num = $sformatf("%0d", {$urandom, $urandom});
            3, 4: num = limit_numbers[$urandom_range(0, 4)];
            default: begin
                repeat ($urandom_range(1, 24)) s.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
            end
        endcase
        foreach (num[i]) begin
            s.push_back(num[i]);
        end
        if ($urandom_range(0, 1) == 1) begin
            s.push_back(pick_blank());
        end
        // suffix B, KB, MB or GB in random case, or none
        unit_pick = $urandom_range(0, 5);
        if (unit_pick >= 2) begin
            if (unit_pick > 2) begin
                s.push_back(unit_letters[unit_pick - 3] |
                            (($urandom_range(0, 1) == 1) ? CH_CASE : 8'h00));
            end
            s.push_back(CH_B | (($urandom_range(0, 1) == 1) ? CH_CASE : 8'h00));
        end
        repeat ($urandom_range(0, 2)) s.push_back(pick_blank());
        // broken variant: one stray character somewhere
        if (kind == 7) begin
            case ($urandom_range(0, 3))
                0: stray = CH_SPACE;
                1: stray = CH_PLUS;
                2: stray = CH_MINUS;
                default: stray = 8'($urandom_range(0, 255));
            endcase
            s.insert($urandom_range(0, s.size()), stray);
        end
    endtask

    task automatic send_random_strings(input int char_budget);
        text_t t;
        int    sent;
        sent = 0;
        while (sent < char_budget) begin
            make_size_string(t);
            send_bytes(t);
            sent += t.size();
        end
    endtask

    // hand-picked strings: plain and signed numbers, blank, missing number, sign errors, bad suffixes, byte extremes
    task automatic test_directed();
        text_t odd;
        send_text("7");
        send_text("\t");
        send_text("b");
        send_text("5-");
        send_text("-+5");
        send_text("1k b");
        send_text("4mbx");
        send_text("4x");
        send_text("+3Kb");
        odd = {8'h00};
        send_bytes(odd);
        odd = {8'hFF};
        send_bytes(odd);
    endtask

    // strings without suffix pick up the register value
    task automatic test_default_units();
        write_default_units(UNITS_GB);
        send_text("8");
        write_default_units(UNITS_KB);
        send_text(" 9 ");
    endtask

    task automatic test_random_traffic();
        logic [1:0] plan [4];
        plan = '{UNITS_B, UNITS_MB, UNITS_GB, UNITS_KB};
        for (int p = 0; p < 5; p++) begin
            write_default_units((p < 4) ? plan[p] : 2'($urandom_range(0, 3)));
            // one phase runs both sides without idling
            steady_flow = (p == 2);
            send_random_strings(70);
        end
        steady_flow = 1'b0;
    endtask

    // receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        wait_idle();
        sink_hold_cycles = HOLD_CYCLES;
        steady_flow = 1'b1;
        send_random_strings(50);
        steady_flow = 1'b0;
    endtask

    // result side ready pattern
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (sink_hold_cycles > 0) begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                stall = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin
        size_result_t got;
        size_result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got.status    = m_tuser;
            got.value     = m_tdata[63:0];
            got.units     = m_tdata[65:64];
            got.saturated = m_tdata[66];
            if (pending_sizes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected result: status=%0b value=%0d units=%0d sat=%0b",
                             got.status, $signed(got.value), got.units, got.saturated);
                end
            end else begin
                want = pending_sizes.pop_front();
                if (got.status !== want.status || got.value !== want.value ||
                    got.units !== want.units || got.saturated !== want.saturated) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("result mismatch: expected status=%0b value=%0d units=%0d sat=%0b",
                                 want.status, $signed(want.value), want.units, want.saturated);
                        $display("                 actual   status=%0b value=%0d units=%0d sat=%0b",
                                 got.status, $signed(got.value), got.units, got.saturated);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) ||
            (cfg_valid && cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_sizes.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clear_scan();
        default_units = UNITS_B;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_default_units();
        test_random_traffic();
        test_backpressure();
        wait_idle();
        if (mismatch_count == 0 && pending_sizes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
